>>> hw/rtl/cell_volume_relaxation_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cell volume block.
// ----------------------------------------------------------------------------
`ifndef CELL_VOLUME_RELAXATION_STEP_MACROS_SVH
`define CELL_VOLUME_RELAXATION_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CVRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define CVRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cvrs_pkg.sv
// ----------------------------------------------------------------------------
// Cell volume package
// Formats, constants, sequencer codes and helper functions of the block.
// ----------------------------------------------------------------------------
package cvrs_pkg;

  localparam int FRACTION_BITS        = 24;
  localparam int VOLUME_FRACTION_BITS = 16;

  localparam int VOL_W      = 32;
  localparam int RAD_W      = 24;
  localparam int SHARE_W    = 25;
  localparam int DT_W       = 16;
  localparam int RATIO_W    = 24;
  localparam int GAIN_W     = DT_W + SHARE_W;
  localparam int OPA_W      = 64;
  localparam int OPB_W      = 32;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SHARE_W-1:0] ONE_SHARE = SHARE_W'(64'd1 << FRACTION_BITS);
  localparam logic [VOL_W-1:0]   VOL_MAX   = '1;
  localparam logic [RAD_W-1:0]   RAD_MAX   = '1;

  localparam logic [OPB_W-1:0] INV_SPHERE_Q32 = 32'd1025347914;
  localparam logic [OPB_W-1:0] FOUR_PI_Q28    = 32'd3373259426;
  localparam logic [OPB_W-1:0] SPHERE_Q28     = 32'd1124419809;

  localparam int SPHERE_SH = 28;
  localparam int VOL3_SH   = 2 * VOLUME_FRACTION_BITS;
  localparam int RELAX_SH  = 8 + FRACTION_BITS;
  localparam int AREA_SH   = 28 + VOLUME_FRACTION_BITS;
  localparam int RAD_E     = 2 * VOLUME_FRACTION_BITS - 32;
  localparam int RAD_SHL   = (RAD_E >= 0) ? RAD_E : 0;
  localparam int RAD_SHR   = (RAD_E < 0) ? -RAD_E : 0;

  localparam int DIV_STEPS  = 32;
  localparam int ROOT_STEPS = 22;
  localparam int ITER_CNT_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLUID_RATE,
    REG_NUCLEAR_SOLID_RATE,
    REG_CYTO_SOLID_RATE,
    REG_TARGET_FLUID,
    REG_TARGET_NUCLEAR,
    REG_CYTO_RATIO
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_LRR, S_LRS, S_LRV, S_LNRR, S_LNRS, S_LNRV, S_LFT, S_LFN, S_LFC,
    S_TF, S_TC, S_GF, S_FL, S_DM, S_DIV, S_GN, S_NS, S_GC, S_CS, S_SUM,
    S_GK, S_CAL, S_VR, S_RT, S_VN, S_RN, S_ARR, S_API
  } step_t;

  typedef enum logic [1:0] {K_MUL, K_ITER, K_LOGIC} kind_t;

  typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_PUBLISH} ctrl_state_t;

  typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI} mul_phase_t;

  typedef enum logic {IM_DIV, IM_ROOT} iter_mode_t;

  typedef struct packed {
    step_t step;
    logic  go;
    logic  load;
    logic  publish;
  } cvrs_cmd_t;

  typedef struct packed {
    logic done;
  } cvrs_status_t;

  function automatic logic [SHARE_W-1:0] sat_share(input logic [SHARE_W-1:0] v);
    sat_share = (v > ONE_SHARE) ? ONE_SHARE : v;
  endfunction

  function automatic logic [VOL_W-1:0] sat_vol(input logic [PROD_W-1:0] v);
    sat_vol = (v > PROD_W'(VOL_MAX)) ? VOL_MAX : v[VOL_W-1:0];
  endfunction

  function automatic kind_t step_kind(input step_t s);
    case (s)
      S_DIV, S_RT, S_RN: step_kind = K_ITER;
      S_SUM:             step_kind = K_LOGIC;
      default:           step_kind = K_MUL;
    endcase
  endfunction

  function automatic step_t next_step(input step_t s);
    case (s)
      S_LFC:   next_step = S_ARR;
      S_API:   next_step = S_LRR;
      default: next_step = step_t'(s + 5'd1);
    endcase
  endfunction

endpackage

>>> hw/rtl/cell_volume_relaxation_step.sv
// ----------------------------------------------------------------------------
// Cell volume relaxation step
// Volume state of one cell, loaded from radii or advanced by one Euler step.
// ----------------------------------------------------------------------------
// Usage: an input beat on in_valid/in_ready carries a command; cmd 1 loads the
// state from the given radii and fluid fraction, cmd 0 advances one time step.
// Each accepted beat yields exactly one result beat on out_valid/out_ready.
// Registers are written over cfg_valid/cfg_ready (ready outside reset) with
// cfg_index and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce it. Unknown indices are ignored.
// One item is processed at a time. A load uses only the shared multiplier;
// an advance also uses the shared iterative unit for a division and two cube
// roots, and skips the division for a zero total or an overflowing quotient.
// The next beat is accepted in the cycle the result appears.
// The result is held in an output register: the next beat is accepted while it
// waits, and a finished item waits for the receiver before overwriting it.
// Synchronous active-low reset clears the state and registers to zero and drops
// out_valid; in_ready and cfg_ready are low during reset and rise once it ends.
// ----------------------------------------------------------------------------
module cell_volume_relaxation_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cvrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [cvrs_pkg::DT_W-1:0]       in_step_length,
  input  logic [cvrs_pkg::SHARE_W-1:0]    in_calcification_rate,
  input  logic [cvrs_pkg::RAD_W-1:0]      in_set_radius,
  input  logic [cvrs_pkg::RAD_W-1:0]      in_set_nuclear_radius,
  input  logic [cvrs_pkg::SHARE_W-1:0]    in_set_fluid_fraction,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cvrs_pkg::VOL_W-1:0]      out_total_volume,
  output logic [cvrs_pkg::VOL_W-1:0]      out_nuclear_volume,
  output logic [cvrs_pkg::VOL_W-1:0]      out_solid_volume,
  output logic [cvrs_pkg::VOL_W-1:0]      out_fluid_volume,
  output logic [cvrs_pkg::RAD_W-1:0]      out_cell_radius,
  output logic [cvrs_pkg::RAD_W-1:0]      out_nucleus_radius,
  output logic [cvrs_pkg::VOL_W-1:0]      out_sphere_area,
  output logic [cvrs_pkg::SHARE_W-1:0]    out_calcified_share,
  output logic                            out_zero_total_flag
);
  import cvrs_pkg::*;

  cvrs_cmd_t    cmd;
  cvrs_status_t status;

  assign cfg_ready = rst_n;

  cvrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  cvrs_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_valid             (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_cmd                (in_cmd),
    .in_step_length        (in_step_length),
    .in_calcification_rate (in_calcification_rate),
    .in_set_radius         (in_set_radius),
    .in_set_nuclear_radius (in_set_nuclear_radius),
    .in_set_fluid_fraction (in_set_fluid_fraction),
    .out_total_volume      (out_total_volume),
    .out_nuclear_volume    (out_nuclear_volume),
    .out_solid_volume      (out_solid_volume),
    .out_fluid_volume      (out_fluid_volume),
    .out_cell_radius       (out_cell_radius),
    .out_nucleus_radius    (out_nucleus_radius),
    .out_sphere_area       (out_sphere_area),
    .out_calcified_share   (out_calcified_share),
    .out_zero_total_flag   (out_zero_total_flag)
  );

endmodule

>>> hw/rtl/cvrs_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// 64 by 32 bit product from two 32 by 32 partial products, low half then high.
// ----------------------------------------------------------------------------
`include "cell_volume_relaxation_step_macros.svh"

module cvrs_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cvrs_pkg::OPA_W-1:0]  a,
  input  logic [cvrs_pkg::OPB_W-1:0]  b,
  output logic [cvrs_pkg::PROD_W-1:0] prod,
  output logic                        done
);
  import cvrs_pkg::*;

  mul_phase_t          phase_r, phase_nxt;
  logic [OPA_W-1:0]    a_r;
  logic [OPB_W-1:0]    b_r;
  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic                done_r;
  logic [2*OPB_W-1:0]  pp_lo, pp_hi;

  always_comb begin
    pp_lo     = a_r[OPB_W-1:0] * b_r;
    pp_hi     = a_r[OPA_W-1:OPB_W] * b_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    case (phase_r)
      MP_IDLE: if (start) phase_nxt = MP_LO;
      MP_LO: begin
        acc_nxt   = PROD_W'(pp_lo);
        phase_nxt = MP_HI;
      end
      MP_HI: begin
        acc_nxt   = acc_r + {pp_hi, {OPB_W{1'b0}}};
        phase_nxt = MP_IDLE;
      end
      default: phase_nxt = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == MP_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

  `CVRS_ASSERT_IMPL(a_mul_start_idle, start, phase_r == MP_IDLE, "multiplier started while busy")

endmodule

>>> hw/rtl/cvrs_iter.sv
// ----------------------------------------------------------------------------
// Shared iterative unit
// Restoring division (one quotient bit a cycle) and cube root (one bit a cycle).
// ----------------------------------------------------------------------------
module cvrs_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  cvrs_pkg::iter_mode_t        mode,
  input  logic [cvrs_pkg::OPA_W-1:0]  x,
  input  logic [cvrs_pkg::OPB_W-1:0]  d,
  output logic [cvrs_pkg::OPB_W-1:0]  res,
  output logic                        done
);
  import cvrs_pkg::*;

  logic                  busy_r, done_r;
  iter_mode_t            mode_r;
  logic [ITER_CNT_W-1:0] cnt_r;
  logic [OPA_W-1:0]      rem_r;
  logic [OPA_W+1:0]      src_r;
  logic [OPB_W-1:0]      res_r, d_r;

  logic [ROOT_STEPS-1:0] y2;
  logic [ROOT_STEPS:0]   y2p1;
  logic [2*ROOT_STEPS:0] yy;
  logic [OPA_W-1:0]      bval, r2, cand;
  logic                  take;

  always_comb begin
    y2   = {res_r[ROOT_STEPS-2:0], 1'b0};
    y2p1 = {1'b0, y2} + (ROOT_STEPS+1)'(1);
    yy   = (2*ROOT_STEPS+1)'(y2) * (2*ROOT_STEPS+1)'(y2p1);
    bval = OPA_W'(yy) + OPA_W'({yy, 1'b0}) + OPA_W'(1);
    if (mode_r == IM_DIV) begin
      r2   = {rem_r[OPA_W-2:0], src_r[OPA_W+1]};
      cand = OPA_W'(d_r);
    end else begin
      r2   = {rem_r[OPA_W-4:0], src_r[OPA_W+1:OPA_W-1]};
      cand = bval;
    end
    take = (r2 >= cand);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= (mode == IM_DIV) ? ITER_CNT_W'(DIV_STEPS) : ITER_CNT_W'(ROOT_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_CNT_W'(1);
        if (cnt_r == ITER_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      d_r    <= d;
      res_r  <= '0;
      if (mode == IM_DIV) begin
        rem_r <= OPA_W'(x[OPA_W-1:OPB_W]);
        src_r <= {x[OPB_W-1:0], {(OPA_W+2-OPB_W){1'b0}}};
      end else begin
        rem_r <= '0;
        src_r <= {2'b00, x};
      end
    end else if (busy_r) begin
      rem_r <= take ? (r2 - cand) : r2;
      res_r <= {res_r[OPB_W-2:0], take};
      if (mode_r == IM_DIV) src_r <= {src_r[OPA_W:0], 1'b0};
      else src_r <= {src_r[OPA_W-2:0], 3'b000};
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

>>> hw/rtl/cvrs_datapath.sv
// ----------------------------------------------------------------------------
// Cell volume datapath
// Configuration, cell state, shared arithmetic units and result registers.
// ----------------------------------------------------------------------------
module cvrs_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cvrs_pkg::cvrs_cmd_t                  cmd,
  output cvrs_pkg::cvrs_status_t               status,
  input  logic                                 cfg_valid,
  input  logic [cvrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cvrs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_cmd,
  input  logic [cvrs_pkg::DT_W-1:0]            in_step_length,
  input  logic [cvrs_pkg::SHARE_W-1:0]         in_calcification_rate,
  input  logic [cvrs_pkg::RAD_W-1:0]           in_set_radius,
  input  logic [cvrs_pkg::RAD_W-1:0]           in_set_nuclear_radius,
  input  logic [cvrs_pkg::SHARE_W-1:0]         in_set_fluid_fraction,
  output logic [cvrs_pkg::VOL_W-1:0]           out_total_volume,
  output logic [cvrs_pkg::VOL_W-1:0]           out_nuclear_volume,
  output logic [cvrs_pkg::VOL_W-1:0]           out_solid_volume,
  output logic [cvrs_pkg::VOL_W-1:0]           out_fluid_volume,
  output logic [cvrs_pkg::RAD_W-1:0]           out_cell_radius,
  output logic [cvrs_pkg::RAD_W-1:0]           out_nucleus_radius,
  output logic [cvrs_pkg::VOL_W-1:0]           out_sphere_area,
  output logic [cvrs_pkg::SHARE_W-1:0]         out_calcified_share,
  output logic                                 out_zero_total_flag
);
  import cvrs_pkg::*;

  logic [SHARE_W-1:0] fr_r, nsr_r, csr_r, tfs_r;
  logic [VOL_W-1:0]   tns_r;
  logic [RATIO_W-1:0] ratio_r;

  logic [DT_W-1:0]    dt_r;
  logic [SHARE_W-1:0] calin_r, setf_r;

  logic [VOL_W-1:0]   fl_r, ns_r, cs_r, tot_r, nuc_r;
  logic [SHARE_W-1:0] cal_r;
  logic [RAD_W-1:0]   rad_r, nrad_r;

  logic [OPA_W-1:0]   t0_r;
  logic [VOL_W-1:0]   tf_r, tc_r, nfl_r, area_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               flag_r, rsat_r;

  logic [OPA_W-1:0]   mul_a;
  logic [OPB_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               mul_start, mul_done;
  logic               it_start, it_done, it_skip;
  iter_mode_t         it_mode;
  logic [OPB_W-1:0]   it_res;

  kind_t              kind;
  logic               done;
  logic [SHARE_W-1:0] f_sat;
  logic [VOL_W-1:0]   cyto, fdiff, nsdiff, csdiff, frac_part, cfl;
  logic [VOL_W:0]     nuc_sum, cyt_sum, tot_sum;
  logic [VOL_W-1:0]   nuc_s, cyt_s;
  logic [PROD_W-1:0]  cal_sum;
  logic [2*OPA_W-1:0] rad_wide;
  logic [VOL_W:0]     solid_sum;

  function automatic logic [VOL_W-1:0] relax(input logic [VOL_W-1:0]  cur,
                                             input logic [VOL_W-1:0]  tgt,
                                             input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] q;
    logic [VOL_W:0]    s;
    q = p >> RELAX_SH;
    s = {1'b0, sat_vol(q)} + {1'b0, cur};
    if (tgt >= cur) relax = s[VOL_W] ? VOL_MAX : s[VOL_W-1:0];
    else if (q >= PROD_W'(cur)) relax = '0;
    else relax = cur - q[VOL_W-1:0];
  endfunction

  cvrs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  cvrs_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (it_start),
    .mode  (it_mode),
    .x     (t0_r),
    .d     (tot_r),
    .res   (it_res),
    .done  (it_done)
  );

  always_comb begin
    kind      = step_kind(cmd.step);
    f_sat     = sat_share(setf_r);
    cyto      = (tot_r > nuc_r) ? (tot_r - nuc_r) : '0;
    fdiff     = (tf_r >= fl_r) ? (tf_r - fl_r) : (fl_r - tf_r);
    nsdiff    = (tns_r >= ns_r) ? (tns_r - ns_r) : (ns_r - tns_r);
    csdiff    = (tc_r >= cs_r) ? (tc_r - cs_r) : (cs_r - tc_r);
    frac_part = VOL_W'(mul_p >> FRACTION_BITS);
    cfl       = (fl_r > nfl_r) ? (fl_r - nfl_r) : '0;
    nuc_sum   = {1'b0, ns_r} + {1'b0, nfl_r};
    nuc_s     = nuc_sum[VOL_W] ? VOL_MAX : nuc_sum[VOL_W-1:0];
    cyt_sum   = {1'b0, cs_r} + {1'b0, cfl};
    cyt_s     = cyt_sum[VOL_W] ? VOL_MAX : cyt_sum[VOL_W-1:0];
    tot_sum   = {1'b0, nuc_s} + {1'b0, cyt_s};
    cal_sum   = PROD_W'(cal_r) + (mul_p >> RELAX_SH);
    rad_wide  = ({{OPA_W{1'b0}}, mul_p[OPA_W-1:0]} << RAD_SHL) >> RAD_SHR;
    solid_sum = {1'b0, ns_r} + {1'b0, cs_r};

    it_mode = (cmd.step == S_DIV) ? IM_DIV : IM_ROOT;
    if (cmd.step == S_DIV) it_skip = (tot_r == '0) || (t0_r[OPA_W-1:OPB_W] >= tot_r);
    else it_skip = rsat_r;

    case (kind)
      K_MUL:   done = mul_done;
      K_ITER:  done = it_skip ? cmd.go : it_done;
      default: done = cmd.go;
    endcase
    mul_start = cmd.go && (kind == K_MUL);
    it_start  = cmd.go && (kind == K_ITER) && !it_skip;

    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      S_LRR:  begin mul_a = OPA_W'(rad_r);   mul_b = OPB_W'(rad_r); end
      S_LRS:  begin mul_a = t0_r;            mul_b = SPHERE_Q28; end
      S_LRV:  begin mul_a = t0_r;            mul_b = OPB_W'(rad_r); end
      S_LNRR: begin mul_a = OPA_W'(nrad_r);  mul_b = OPB_W'(nrad_r); end
      S_LNRS: begin mul_a = t0_r;            mul_b = SPHERE_Q28; end
      S_LNRV: begin mul_a = t0_r;            mul_b = OPB_W'(nrad_r); end
      S_LFT:  begin mul_a = OPA_W'(f_sat);   mul_b = tot_r; end
      S_LFN:  begin mul_a = OPA_W'(f_sat);   mul_b = nuc_r; end
      S_LFC:  begin mul_a = OPA_W'(f_sat);   mul_b = cyto; end
      S_TF:   begin mul_a = OPA_W'(sat_share(tfs_r)); mul_b = tot_r; end
      S_TC:   begin mul_a = OPA_W'(tns_r);   mul_b = OPB_W'(ratio_r); end
      S_GF:   begin mul_a = OPA_W'(dt_r);    mul_b = OPB_W'(sat_share(fr_r)); end
      S_FL:   begin mul_a = OPA_W'(gain_r);  mul_b = fdiff; end
      S_DM:   begin mul_a = OPA_W'(nuc_r);   mul_b = fl_r; end
      S_GN:   begin mul_a = OPA_W'(dt_r);    mul_b = OPB_W'(sat_share(nsr_r)); end
      S_NS:   begin mul_a = OPA_W'(gain_r);  mul_b = nsdiff; end
      S_GC:   begin mul_a = OPA_W'(dt_r);    mul_b = OPB_W'(sat_share(csr_r)); end
      S_CS:   begin mul_a = OPA_W'(gain_r);  mul_b = csdiff; end
      S_GK:   begin mul_a = OPA_W'(dt_r);    mul_b = OPB_W'(sat_share(calin_r)); end
      S_CAL:  begin mul_a = OPA_W'(gain_r);  mul_b = OPB_W'(ONE_SHARE - cal_r); end
      S_VR:   begin mul_a = OPA_W'(tot_r);   mul_b = INV_SPHERE_Q32; end
      S_VN:   begin mul_a = OPA_W'(nuc_r);   mul_b = INV_SPHERE_Q32; end
      S_ARR:  begin mul_a = OPA_W'(rad_r);   mul_b = OPB_W'(rad_r); end
      S_API:  begin mul_a = t0_r;            mul_b = FOUR_PI_Q28; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign status.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r    <= '0;
      nsr_r   <= '0;
      csr_r   <= '0;
      tfs_r   <= '0;
      tns_r   <= '0;
      ratio_r <= '0;
      fl_r    <= '0;
      ns_r    <= '0;
      cs_r    <= '0;
      tot_r   <= '0;
      nuc_r   <= '0;
      cal_r   <= '0;
      rad_r   <= '0;
      nrad_r  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_FLUID_RATE:         fr_r    <= cfg_data[SHARE_W-1:0];
          REG_NUCLEAR_SOLID_RATE: nsr_r   <= cfg_data[SHARE_W-1:0];
          REG_CYTO_SOLID_RATE:    csr_r   <= cfg_data[SHARE_W-1:0];
          REG_TARGET_FLUID:       tfs_r   <= cfg_data[SHARE_W-1:0];
          REG_TARGET_NUCLEAR:     tns_r   <= cfg_data[VOL_W-1:0];
          REG_CYTO_RATIO:         ratio_r <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load && in_cmd) begin
        rad_r  <= in_set_radius;
        nrad_r <= in_set_nuclear_radius;
      end
      if (done) begin
        case (cmd.step)
          S_LRV:  tot_r <= sat_vol(mul_p >> VOL3_SH);
          S_LNRV: nuc_r <= sat_vol(mul_p >> VOL3_SH);
          S_LFT:  fl_r  <= frac_part;
          S_LFN:  ns_r  <= nuc_r - frac_part;
          S_LFC:  cs_r  <= cyto - frac_part;
          S_FL:   fl_r  <= relax(fl_r, tf_r, mul_p);
          S_NS:   ns_r  <= relax(ns_r, tns_r, mul_p);
          S_CS:   cs_r  <= relax(cs_r, tc_r, mul_p);
          S_SUM: begin
            nuc_r <= nuc_s;
            tot_r <= tot_sum[VOL_W] ? VOL_MAX : tot_sum[VOL_W-1:0];
          end
          S_CAL:  cal_r <= (cal_sum > PROD_W'(ONE_SHARE)) ? ONE_SHARE
                                                         : cal_sum[SHARE_W-1:0];
          S_RT:   rad_r <= (rsat_r || (it_res > OPB_W'(RAD_MAX))) ? RAD_MAX
                                                                  : it_res[RAD_W-1:0];
          S_RN:   nrad_r <= (rsat_r || (it_res > OPB_W'(RAD_MAX))) ? RAD_MAX
                                                                   : it_res[RAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dt_r    <= in_step_length;
      calin_r <= in_calcification_rate;
      setf_r  <= in_set_fluid_fraction;
      flag_r  <= 1'b0;
    end
    if (done) begin
      case (cmd.step)
        S_LRR, S_LNRR, S_DM, S_ARR: t0_r <= mul_p[OPA_W-1:0];
        S_LRS, S_LNRS:              t0_r <= OPA_W'(mul_p >> SPHERE_SH);
        S_TF:                       tf_r <= frac_part;
        S_TC:                       tc_r <= sat_vol(mul_p >> VOLUME_FRACTION_BITS);
        S_GF, S_GN, S_GC, S_GK:     gain_r <= mul_p[GAIN_W-1:0];
        S_DIV: begin
          if (tot_r == '0) begin
            nfl_r  <= '0;
            flag_r <= 1'b1;
          end else if (it_skip) begin
            nfl_r <= VOL_MAX;
          end else begin
            nfl_r <= it_res;
          end
        end
        S_VR, S_VN: begin
          t0_r   <= rad_wide[OPA_W-1:0];
          rsat_r <= |rad_wide[2*OPA_W-1:OPA_W];
        end
        S_API: area_r <= sat_vol(mul_p >> AREA_SH);
        default: ;
      endcase
    end
    if (cmd.publish) begin
      out_total_volume    <= tot_r;
      out_nuclear_volume  <= nuc_r;
      out_solid_volume    <= solid_sum[VOL_W] ? VOL_MAX : solid_sum[VOL_W-1:0];
      out_fluid_volume    <= fl_r;
      out_cell_radius     <= rad_r;
      out_nucleus_radius  <= nrad_r;
      out_sphere_area     <= area_r;
      out_calcified_share <= cal_r;
      out_zero_total_flag <= flag_r;
    end
  end

endmodule

>>> hw/rtl/cvrs_ctrl.sv
// ----------------------------------------------------------------------------
// Cell volume controller
// Accepts items, steps the datapath through its sequence and hands off results.
// ----------------------------------------------------------------------------
`include "cell_volume_relaxation_step_macros.svh"

module cvrs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cvrs_pkg::cvrs_cmd_t    cmd,
  input  cvrs_pkg::cvrs_status_t status
);
  import cvrs_pkg::*;

  ctrl_state_t state_r, state_nxt;
  step_t       step_r, step_nxt;
  logic        go_r, go_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      step_r      <= S_LRR;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    go_nxt      = 1'b0;
    in_ready    = 1'b0;
    cmd.step    = step_r;
    cmd.go      = go_r;
    cmd.load    = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          step_nxt  = in_cmd ? S_LRR : S_TF;
          go_nxt    = 1'b1;
          state_nxt = CS_RUN;
        end
      end
      CS_RUN: begin
        if (status.done) begin
          if (step_r == S_API) begin
            state_nxt = CS_PUBLISH;
          end else begin
            step_nxt = next_step(step_r);
            go_nxt   = 1'b1;
          end
        end
      end
      CS_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
    if (cmd.publish) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  `CVRS_ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid_r, "result lost after hand-off")
  `CVRS_ASSERT_NEXT(a_accept_run, in_valid && in_ready, state_r == CS_RUN, "accepted beat not run")
  `CVRS_ASSERT_IMPL(a_done_in_run, status.done, state_r == CS_RUN, "datapath finished a step outside a run")

endmodule
